// ===== hw/rtl/mfifo_pkg.sv =====
package mfifo_pkg;

  // field widths fixed by the item format
  localparam int ActW    = 2;
  localparam int ByteW   = 8;
  localparam int LenW    = 7;
  localparam int CountW  = 5;
  localparam int DepthW  = 5;
  localparam int StatusW = 3;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 7;

  // action codes of an input item
  localparam logic [ActW-1:0] ACT_SEND_BEGIN = 2'd0;
  localparam logic [ActW-1:0] ACT_SEND_BYTE  = 2'd1;
  localparam logic [ActW-1:0] ACT_RECEIVE    = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_QUEUE_DEPTH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MSG_SIZE    = 1'b1;

  // configuration reset values
  localparam logic [DepthW-1:0] DepthRst = 5'd16;
  localparam logic [LenW-1:0]   SizeRst  = 7'd64;

  // stored message count saturates here
  localparam logic [CountW-1:0] CountMax = 5'd31;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_SIZE   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_NOSEND = 3'd4
  } mfifo_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_LEN,
    S_STREAM
  } mfifo_state_e;

  typedef struct packed {
    mfifo_status_e     status;
    logic [ByteW-1:0]  data_byte;
    logic [LenW-1:0]   length;
    logic              has_byte;
    logic              last;
    logic [CountW-1:0] count;
  } mfifo_res_t;

endpackage

// ===== hw/rtl/message_fifo_length_prefixed.sv =====
// Length-prefixed message queue: a ring of fixed-size slots, each holding a
// length and up to MAX_MSG_BYTES payload bytes.
// Input channel (in_valid_i/in_ready_o) carries an action with msg_length_i
// and data_byte_i. A send begin opens a slot, send bytes fill it and the
// message commits when its length is reached. A receive streams the oldest
// message out one byte per result with a last mark and frees its slot.
// Output channel (out_valid_o/out_ready_i) carries one result per send item
// and one result per payload byte (or one result) per receive item.
// Send items: the result is registered as the item is accepted, and a new item
// can be taken every cycle while results are drained.
// Receive items: the stored length is read, S_RD_LEN fetches the first
// byte, then S_STREAM gives one byte per cycle while the result register
// is free; no new item is taken until the message is out. The single
// address adder into the payload memory walks the slot for the bytes.
// Reset clears pointers, count and the open send; configuration returns to
// depth 16 and message size 64. Store contents are not cleared.
// A stalled receiver holds the result register; the block pushes no result
// and accepts nothing until the register frees up.
module message_fifo_length_prefixed #(
  parameter int MAX_DEPTH     = 16,
  parameter int MAX_MSG_BYTES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [mfifo_pkg::ActW-1:0]         action_i,
  input  logic [mfifo_pkg::ByteW-1:0]        msg_length_i,
  input  logic [mfifo_pkg::ByteW-1:0]        data_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mfifo_pkg::StatusW-1:0]      status_o,
  output logic [mfifo_pkg::ByteW-1:0]        data_byte_out_o,
  output logic [mfifo_pkg::LenW-1:0]         length_out_o,
  output logic                               has_byte_o,
  output logic                               last_o,
  output logic [mfifo_pkg::CountW-1:0]       msg_count_o,
  input  logic                               cfg_we_i,
  input  logic [mfifo_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [mfifo_pkg::CfgW-1:0]         cfg_wdata_i
);

  localparam int SW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CmpW  = ($clog2(MAX_DEPTH + 1) > 5) ? $clog2(MAX_DEPTH + 1) : 5;
  localparam int Words = MAX_DEPTH * MAX_MSG_BYTES;
  localparam int AW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int LenW  = mfifo_pkg::LenW;
  localparam int CntW  = mfifo_pkg::CountW;

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_MSG_BYTES);

  mfifo_pkg::mfifo_state_e state_q, state_d;

  logic [SW-1:0]   ws_q, ws_d, rs_q, rs_d;
  logic [CntW-1:0] count_q, count_d;
  logic            open_q, open_d;
  logic [LenW-1:0] bw_q, bw_d, target_q, target_d;
  logic [LenW-1:0] len_q, len_d, idx_q, idx_d;
  logic [AW-1:0]   base_q, base_d;
  logic [mfifo_pkg::DepthW-1:0] depth_q;
  logic [LenW-1:0] size_q;

  logic [CmpW-1:0] eff_depth;
  logic [LenW-1:0] eff_size;
  logic [LenW-1:0] len_c;
  logic            stream_last;
  logic            in_acc;
  logic            out_free;
  logic            push;
  mfifo_pkg::mfifo_res_t res, res_out;

  logic            len_we, len_re, pay_we, pay_re;
  logic [AW-1:0]   addr_base, addr_off, addr;
  logic [LenW-1:0] len_mem [MAX_DEPTH];
  logic [LenW-1:0] len_rdata_q;
  logic [mfifo_pkg::ByteW-1:0] pay_mem [Words];
  logic [mfifo_pkg::ByteW-1:0] pay_rdata_q;

  // slot after s, wrapping at the effective depth or the last slot
  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s,
                                              input logic [CmpW-1:0] dep);
    logic [CmpW-1:0] sp1;
    sp1 = CmpW'(s) + CmpW'(1);
    if (sp1 >= dep || sp1 >= CmpW'(MAX_DEPTH)) begin
      return '0;
    end
    return SW'(sp1);
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= mfifo_pkg::DepthRst;
      size_q  <= mfifo_pkg::SizeRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mfifo_pkg::CFG_QUEUE_DEPTH: depth_q <= cfg_wdata_i[mfifo_pkg::DepthW-1:0];
        mfifo_pkg::CFG_MSG_SIZE:    size_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamped configuration
  assign eff_depth = (depth_q == '0) ? CmpW'(1) :
                     (CmpW'(depth_q) > CmpW'(MAX_DEPTH)) ? CmpW'(MAX_DEPTH) :
                     CmpW'(depth_q);
  assign eff_size  = (size_q == '0) ? LenW'(1) : (size_q > MaxLen) ? MaxLen : size_q;

  assign len_c       = (len_rdata_q > MaxLen) ? MaxLen : len_rdata_q;
  assign stream_last = ((idx_q + LenW'(1)) == len_q);
  assign in_ready_o  = (state_q == mfifo_pkg::S_IDLE) && out_free;
  assign in_acc      = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mfifo_pkg::S_IDLE: begin
        if (in_acc && action_i == mfifo_pkg::ACT_RECEIVE && count_q != '0) begin
          state_d = mfifo_pkg::S_RD_LEN;
        end
      end
      mfifo_pkg::S_RD_LEN: begin
        if (len_c != '0) begin
          state_d = mfifo_pkg::S_STREAM;
        end else if (out_free) begin
          state_d = mfifo_pkg::S_IDLE;
        end
      end
      mfifo_pkg::S_STREAM: begin
        if (out_free && stream_last) begin
          state_d = mfifo_pkg::S_IDLE;
        end
      end
      default: state_d = mfifo_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    push      = 1'b0;
    res       = '{status: mfifo_pkg::ST_OK, data_byte: '0, length: '0,
                  has_byte: 1'b0, last: 1'b1, count: count_q};
    ws_d      = ws_q;
    rs_d      = rs_q;
    count_d   = count_q;
    open_d    = open_q;
    bw_d      = bw_q;
    target_d  = target_q;
    base_d    = base_q;
    len_d     = len_q;
    idx_d     = idx_q;
    len_we    = 1'b0;
    len_re    = 1'b0;
    pay_we    = 1'b0;
    pay_re    = 1'b0;
    addr_base = AW'(ws_q) * AW'(MAX_MSG_BYTES);
    addr_off  = AW'(bw_q);
    case (state_q)
      mfifo_pkg::S_IDLE: begin
        if (in_acc) begin
          case (action_i)
            mfifo_pkg::ACT_SEND_BEGIN: begin
              push   = 1'b1;
              open_d = 1'b0;
              bw_d   = '0;
              if (CmpW'(count_q) >= eff_depth) begin
                res.status = mfifo_pkg::ST_FULL;
              end else if (msg_length_i > {1'b0, eff_size}) begin
                res.status = mfifo_pkg::ST_SIZE;
              end else begin
                len_we   = 1'b1;
                target_d = msg_length_i[LenW-1:0];
                if (msg_length_i == '0) begin
                  ws_d    = next_slot(ws_q, eff_depth);
                  count_d = (count_q != mfifo_pkg::CountMax) ? count_q + CntW'(1) : count_q;
                end else begin
                  open_d = 1'b1;
                end
              end
              res.count = count_d;
            end
            mfifo_pkg::ACT_SEND_BYTE: begin
              push = 1'b1;
              if (!open_q) begin
                res.status = mfifo_pkg::ST_NOSEND;
              end else begin
                pay_we = 1'b1;
                bw_d   = bw_q + LenW'(1);
                if (bw_d >= target_q) begin
                  open_d  = 1'b0;
                  bw_d    = '0;
                  ws_d    = next_slot(ws_q, eff_depth);
                  count_d = (count_q != mfifo_pkg::CountMax) ? count_q + CntW'(1) : count_q;
                end
              end
              res.count = count_d;
            end
            mfifo_pkg::ACT_RECEIVE: begin
              if (count_q == '0) begin
                push       = 1'b1;
                res.status = mfifo_pkg::ST_EMPTY;
              end else begin
                len_re  = 1'b1;
                count_d = count_q - CntW'(1);
                rs_d    = next_slot(rs_q, eff_depth);
                base_d  = AW'(rs_q) * AW'(MAX_MSG_BYTES);
              end
            end
            default: ;
          endcase
        end
      end
      mfifo_pkg::S_RD_LEN: begin
        addr_base = base_q;
        addr_off  = '0;
        if (len_c == '0) begin
          push = out_free;
        end else begin
          len_d  = len_c;
          idx_d  = '0;
          pay_re = 1'b1;
        end
      end
      mfifo_pkg::S_STREAM: begin
        addr_base = base_q;
        addr_off  = AW'(idx_q + LenW'(1));
        if (out_free) begin
          push          = 1'b1;
          res.data_byte = pay_rdata_q;
          res.length    = len_q;
          res.has_byte  = 1'b1;
          res.last      = stream_last;
          if (!stream_last) begin
            idx_d  = idx_q + LenW'(1);
            pay_re = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // shared slot address adder
  assign addr = addr_base + addr_off;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfifo_pkg::S_IDLE;
      ws_q    <= '0;
      rs_q    <= '0;
      count_q <= '0;
      open_q  <= 1'b0;
      bw_q    <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ws_q    <= ws_d;
      rs_q    <= rs_d;
      count_q <= count_d;
      open_q  <= open_d;
      bw_q    <= bw_d;
      idx_q   <= idx_d;
    end
  end

  // per-message working registers
  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    base_q   <= base_d;
    len_q    <= len_d;
  end

  // length store
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[ws_q] <= msg_length_i[LenW-1:0];
    end
    if (len_re) begin
      len_rdata_q <= len_mem[rs_q];
    end
  end

  // payload store
  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[addr] <= data_byte_i;
    end
    if (pay_re) begin
      pay_rdata_q <= pay_mem[addr];
    end
  end

  // result register
  mfifo_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .res_o   (res_out),
    .free_o  (out_free)
  );

  assign status_o        = res_out.status;
  assign data_byte_out_o = res_out.data_byte;
  assign length_out_o    = res_out.length;
  assign has_byte_o      = res_out.has_byte;
  assign last_o          = res_out.last;
  assign msg_count_o     = res_out.count;

  // a result is only pushed into a free result register
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result pushed into a busy result register");

  // a receive on a non-empty queue goes on to read the stored length
  a_recv_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && action_i == mfifo_pkg::ACT_RECEIVE && count_q != '0)
      |=> state_q == mfifo_pkg::S_RD_LEN)
    else $error("receive did not start the length read");

  // the stream index stays inside the message
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfifo_pkg::S_STREAM) |-> (idx_q < len_q))
    else $error("stream index past message length");

  // slot pointers stay inside the ring
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CmpW'(ws_q) < CmpW'(MAX_DEPTH)) && (CmpW'(rs_q) < CmpW'(MAX_DEPTH)))
    else $error("slot pointer out of range");

endmodule

// ===== hw/rtl/mfifo_out_reg.sv =====
module mfifo_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mfifo_pkg::mfifo_res_t res_i,
  input  logic               ready_i,
  output logic               valid_o,
  output mfifo_pkg::mfifo_res_t res_o,
  output logic               free_o
);

  logic                  valid_q, valid_d;
  mfifo_pkg::mfifo_res_t res_q;

  // slot is free when empty or being taken this cycle
  assign free_o = !valid_q || ready_i;

  // valid flag
  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
